// ===== hdl/csb_pkg.sv =====
// shared types and constants for the bounded byte sequence
// word layouts, operation codes and the default capacity
// no dependencies
package csb_pkg;

    localparam int unsigned CAPACITY_DEF = 128;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] value;
        logic [6:0] index;
    } t_in_word;

    typedef struct packed {
        logic [7:0] count;
        logic       found;
        logic [6:0] position;
        logic [7:0] data_out;
        logic       dropped;
    } t_out_word;

    // address width of a store of n entries, at least one bit
    function automatic int unsigned f_addr_w(input int unsigned n);
        f_addr_w = (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ===== hdl/csb_ram.sv =====
// generic simple dual-port ram, one write port and one read port
// read data registered; no dependencies
module csb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/char_sequence_buffer_remove_all.sv =====
// bounded byte sequence: append, first-match search, indexed read, remove-all
// append: result goes through the done state to the output register; read: through the read-data state, then done
// search and remove-all walk the store through one ram read port and one compare,
// one entry a cycle; a search stops early when it hits
// one word in flight; input is stalled until its result moves to the output register
// synchronous active-low reset empties the store (fill count 0); ram contents are not cleared
module char_sequence_buffer_remove_all
    import csb_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out
);

    localparam int unsigned AW   = f_addr_w(CAPACITY);
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = (CW > 7) ? CW : 7;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_RDATA = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_op, n_op;
    logic [7:0]    r_val, n_val;
    logic [CW-1:0] r_ptr, n_ptr;
    logic          r_chk, n_chk;
    logic [AW-1:0] r_chk_idx, n_chk_idx;
    logic [CW-1:0] r_wr, n_wr;
    t_out_word     r_res, n_res;
    logic          r_out_valid, n_out_valid;
    t_out_word     r_out, n_out;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic          w_match;

    csb_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // the one compare shared by search and remove-all
    assign w_match = (ram_rdata == r_val);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_op        = r_op;
        n_val       = r_val;
        n_ptr       = r_ptr;
        n_chk       = r_chk;
        n_chk_idx   = r_chk_idx;
        n_wr        = r_wr;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_wr[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = r_ptr[AW-1:0];

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op  = i_in.op;
                    n_val = i_in.value;
                    n_res = '0;
                    n_ptr = '0;
                    n_chk = 1'b0;
                    n_wr  = '0;
                    unique case (i_in.op)
                        OP_APPEND: begin
                            if (r_count < CW'(CAPACITY)) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[AW-1:0];
                                ram_wdata = i_in.value;
                                n_count   = r_count + 1'b1;
                            end else begin
                                n_res.dropped = 1'b1;
                            end
                            n_state = ST_DONE;
                        end
                        OP_READ: begin
                            ram_raddr = AW'(i_in.index);
                            if (CMPW'(i_in.index) < CMPW'(r_count)) begin
                                n_res.found = 1'b1;
                                n_chk       = 1'b1;
                            end
                            n_state = ST_RDATA;
                        end
                        OP_SEARCH, OP_REMOVE: begin
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RDATA: begin
                if (r_chk) begin
                    n_res.data_out = ram_rdata;
                end
                n_chk   = 1'b0;
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                // issue the next read while the previous byte is checked
                if (r_ptr < r_count) begin
                    n_ptr     = r_ptr + 1'b1;
                    n_chk     = 1'b1;
                    n_chk_idx = r_ptr[AW-1:0];
                end else begin
                    n_chk = 1'b0;
                end
                if (r_chk) begin
                    if (r_op == OP_SEARCH) begin
                        if (w_match) begin
                            n_res.found    = 1'b1;
                            n_res.position = 7'(r_chk_idx);
                            n_chk          = 1'b0;
                            n_state        = ST_DONE;
                        end
                    end else if (!w_match) begin
                        // keep the byte, compacting it down to the write pointer
                        ram_we = 1'b1;
                        n_wr   = r_wr + 1'b1;
                    end
                end
                if ((r_ptr >= r_count) && !r_chk) begin
                    n_state = ST_DONE;
                    if (r_op == OP_REMOVE) begin
                        n_count = r_wr;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_out.count = 8'(r_count);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_chk       <= n_chk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_val     <= n_val;
        r_ptr     <= n_ptr;
        r_chk_idx <= n_chk_idx;
        r_wr      <= n_wr;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
